@@ rtl/zin_pkg.sv @@
// Shared constants, register indexes and lane-to-merge types for the zone input qualifier.
package zin_pkg;

  localparam int ZONES_DEF = 4;
  localparam int IN_W      = 4;
  localparam int LVL_W     = 8;
  localparam int ZNUM_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [LVL_W-1:0] DET_CONTRIB = LVL_W'(32);
  localparam logic [CFG_W-1:0] PANEL_RST   = CFG_W'(0);
  localparam logic [CFG_W-1:0] RISE_RST    = CFG_W'(120);
  localparam logic [CFG_W-1:0] FALL_RST    = CFG_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PANEL = 2'd0,
    CFG_RISE  = 2'd1,
    CFG_FALL  = 2'd2
  } zin_cfg_e;

  typedef struct packed {
    logic changed;
    logic on;
  } zin_evt_t;

endpackage

@@ rtl/zone_input_qualifier.sv @@
// Top level of the zone input qualifier: configuration registers, zone lanes and event merge.
//
// Each input beat on the in channel is one sampling tick carrying the raw pin levels
// of the zones; a low pin counts as detection. Every zone has its own lane that runs
// the averaging filter and the hysteresis comparison, so all zones of a tick are
// qualified in the cycle the beat is accepted. The merge stage then issues one output
// beat per state change, lowest zone first, with last_event_o set on the final one.
// A tick that changes no zone produces no output beat at all.
// An accepted tick's transitions are first registered in the pending mask, then moved
// lowest zone first into the output register. While the receiver does not stall, one
// output beat issues per cycle, so a tick with k changes occupies the result channel for
// k beats (up to four with four zones); the next tick is taken in the cycle its
// predecessor's final event moves into the output register, and ticks with no changes
// are taken every cycle. The single-entry pending mask in the merge stage sets this rate.
// When the receiver stalls, the output register holds its beat and the pending mask
// keeps the remaining events; in_ready_o stays low until the last of them moves into the output register.
// Reset clears the filter levels, marks every zone inactive, empties the output and
// restores the panel address to 0, the rise threshold to 120 and the fall threshold
// to 8. Configuration writes are always accepted; unknown indexes are ignored.
module zone_input_qualifier #(
  parameter int ZONES = zin_pkg::ZONES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [zin_pkg::IN_W-1:0]        zone_levels_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [zin_pkg::CFG_W-1:0]       event_panel_o,
  output logic [zin_pkg::ZNUM_W-1:0]      zone_number_o,
  output logic                            zone_on_o,
  output logic                            last_event_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [zin_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [zin_pkg::CFG_W-1:0]       cfg_data_i
);
  import zin_pkg::*;

  logic [CFG_W-1:0] panel_q, rise_q, fall_q;
  logic             in_fire;
  zin_evt_t [ZONES-1:0] lane_evt;

  // The register file never back-pressures the configuration channel.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_q <= PANEL_RST;
      rise_q  <= RISE_RST;
      fall_q  <= FALL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PANEL: panel_q <= cfg_data_i;
        CFG_RISE:  rise_q  <= cfg_data_i;
        CFG_FALL:  fall_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Zones beyond the width of the input field see a low pin and so count as detecting.
  for (genvar g = 0; g < ZONES; g++) begin : g_lane
    logic pin;
    if (g < IN_W) begin : g_pin
      assign pin = zone_levels_i[g];
    end else begin : g_tied
      assign pin = 1'b0;
    end

    zin_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .accept_i   (in_fire),
      .pin_i      (pin),
      .rise_thr_i (rise_q),
      .fall_thr_i (fall_q),
      .evt_o      (lane_evt[g])
    );
  end

  zin_merge #(
    .ZONES (ZONES)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .evt_i         (lane_evt),
    .panel_i       (panel_q),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_panel_o (event_panel_o),
    .zone_number_o (zone_number_o),
    .zone_on_o     (zone_on_o),
    .last_event_o  (last_event_o)
  );

endmodule

@@ rtl/zin_lane.sv @@
// One zone lane: averaging filter, hysteresis state and transition flag.
module zin_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        pin_i,
  input  logic [zin_pkg::CFG_W-1:0]   rise_thr_i,
  input  logic [zin_pkg::CFG_W-1:0]   fall_thr_i,
  output zin_pkg::zin_evt_t           evt_o
);
  import zin_pkg::*;

  logic [LVL_W-1:0] level_q, level_d;
  logic             on_q, on_d;
  logic [LVL_W+1:0] triple;
  logic [LVL_W-1:0] scaled;

  // floor(level * 3 / 4) plus the detection contribution; never exceeds 223.
  assign triple  = {1'b0, level_q, 1'b0} + {2'b00, level_q};
  assign scaled  = triple[LVL_W+1:2];
  assign level_d = scaled + (pin_i ? '0 : DET_CONTRIB);

  always_comb begin
    on_d = on_q;
    if (!on_q && (level_d > rise_thr_i)) begin
      on_d = 1'b1;
    end else if (on_q && (level_d < fall_thr_i)) begin
      on_d = 1'b0;
    end
  end

  assign evt_o.changed = on_d != on_q;
  assign evt_o.on      = on_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      on_q    <= 1'b0;
    end else if (accept_i) begin
      level_q <= level_d;
      on_q    <= on_d;
    end
  end

endmodule

@@ rtl/zin_merge.sv @@
// Merging stage: holds the transitions of one tick and issues them in zone order.
module zin_merge #(
  parameter int ZONES = zin_pkg::ZONES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_fire_i,
  input  zin_pkg::zin_evt_t [ZONES-1:0]  evt_i,
  input  logic [zin_pkg::CFG_W-1:0]      panel_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [zin_pkg::CFG_W-1:0]      event_panel_o,
  output logic [zin_pkg::ZNUM_W-1:0]     zone_number_o,
  output logic                           zone_on_o,
  output logic                           last_event_o
);
  import zin_pkg::*;

  localparam int IDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;

  logic [ZONES-1:0]  pend_q, pend_d;
  logic [ZONES-1:0]  on_q, on_d;
  logic [ZONES-1:0]  low_bit, remain, chg_mask, new_on;
  logic [IDX_W-1:0]  pick_idx;
  logic [IDX_W:0]    num_full;
  logic              load_en;

  logic              out_valid_q;
  logic [CFG_W-1:0]  panel_q;
  logic [ZNUM_W-1:0] znum_q;
  logic              zon_q;
  logic              last_q;

  always_comb begin
    for (int i = 0; i < ZONES; i++) begin
      chg_mask[i] = evt_i[i].changed;
      new_on[i]   = evt_i[i].on;
    end
  end

  assign low_bit = pend_q & (~pend_q + ZONES'(1));
  assign remain  = pend_q & ~low_bit;

  always_comb begin
    pick_idx = '0;
    for (int i = ZONES - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        pick_idx = IDX_W'(i);
      end
    end
  end

  assign num_full   = {1'b0, pick_idx} + (IDX_W+1)'(1);
  assign load_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = (pend_q == '0) || (load_en && (remain == '0));

  always_comb begin
    pend_d = pend_q;
    on_d   = on_q;
    if (load_en && (pend_q != '0)) begin
      pend_d = remain;
    end
    if (in_fire_i) begin
      pend_d = chg_mask;
      on_d   = new_on;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (load_en) begin
        out_valid_q <= pend_q != '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    on_q <= on_d;
    if (load_en && (pend_q != '0)) begin
      panel_q <= panel_i;
      znum_q  <= ZNUM_W'(num_full);
      zon_q   <= on_q[pick_idx];
      last_q  <= remain == '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_panel_o = panel_q;
  assign zone_number_o = znum_q;
  assign zone_on_o     = zon_q;
  assign last_event_o  = last_q;

`ifndef SYNTHESIS
  a_pend_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != '0) |=> out_valid_q)
    else $error("pending transition not moved into the output register");

  a_ready_one_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> ($countones(pend_q) <= 1))
    else $error("new tick taken while several transitions were still pending");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (pend_q != '0))
    else $error("non-final event shown with nothing left to follow");
`endif

endmodule
